// ----- sv/scc_pkg.sv -----
// Shared constants, codes and memory entry layouts for the SCC decomposition block.
// Used by scc_ram and scc_decomposition_top; depends on nothing.
`default_nettype none

package scc_pkg;

  localparam int unsigned MAX_STATES = 1024;
  localparam int unsigned MAX_EDGES  = 8192;
  localparam int unsigned SW   = $clog2(MAX_STATES);
  localparam int unsigned NW   = SW + 1;
  localparam int unsigned EW   = $clog2(MAX_EDGES);
  localparam int unsigned EFW  = EW + 1;
  localparam int unsigned ACTW = 3;
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = NW;

  localparam logic [ACTW-1:0] ACT_MARK  = 3'd0;
  localparam logic [ACTW-1:0] ACT_EDGE  = 3'd1;
  localparam logic [ACTW-1:0] ACT_RUN   = 3'd2;
  localparam logic [ACTW-1:0] ACT_QUERY = 3'd3;
  localparam logic [ACTW-1:0] ACT_CLEAR = 3'd4;

  localparam logic [CFG_IW-1:0] CFG_STATE_COUNT  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DROP_TRIVIAL = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ONLY_BOTTOM  = 2'd2;

  typedef struct packed {
    logic          visited;
    logic          assigned;
    logic          self_loop;
    logic [SW-1:0] pre;
    logic [SW-1:0] comp;
  } node_t;

  typedef struct packed {
    logic [EFW-1:0] lo;
    logic [EFW-1:0] hi;
  } row_t;

  typedef struct packed {
    logic [SW-1:0]  node;
    logic [EFW-1:0] cursor;
  } frame_t;

  typedef struct packed {
    logic [SW-1:0] node;
    logic [SW-1:0] pre;
  } root_t;

  typedef struct packed {
    logic          drop;
    logic [SW-1:0] renum;
  } comp_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_Q1, ST_Q2, ST_RINIT, ST_SCAN, ST_SCAN_W,
    ST_ENTER, ST_EDGE, ST_EDGE_T, ST_EDGE_N, ST_DESC, ST_ROOT, ST_ROOT_W,
    ST_DONE1, ST_DONE2, ST_POPO, ST_POPO_W, ST_COMP, ST_POPW, ST_POPW_W,
    ST_POPW_R, ST_B_RD, ST_B_N, ST_B_C, ST_B_E, ST_B_ET, ST_B_EN,
    ST_RN_RD, ST_RN_W
  } state_t;

endpackage

`default_nettype wire

// ----- sv/scc_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on scc_pkg for its default depth.
`default_nettype none

module scc_ram #(
  parameter int unsigned W = 1,
  parameter int unsigned D = scc_pkg::MAX_STATES
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/scc_decomposition_top.sv -----
// Strongly connected component decomposition: sequencer and graph/search memories.
// Depends on scc_pkg and scc_ram.
//
// Command channel: an item transfers when start is high and busy is low.
// Actions: mark state (no result), add edge (result on the next cycle with
// error_flag), run, query, clear graph (no result).
// Results appear for one cycle with done high; the receiver cannot stall.
// Query: the result follows two dependent memory reads (node, then component);
// a state in no component is answered after the first read.
// Run: clear the per-state memory, then scan each state, enter each subset
// state not yet visited, pop the members of each component and record it;
// each edge examined may be compared against the root stack. The bottom test,
// when enabled, then walks each state and its edges; the renumbering follows.
// Each step reads each single-read-port RAM at most once.
// Reset and clear graph run a clearing pass over every state entry with busy high.
// Configuration writes (cfg_valid/cfg_ready) are taken in any cycle.
`default_nettype none

module scc_decomposition_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [scc_pkg::ACTW-1:0]    action,
  input  wire logic [scc_pkg::SW-1:0]      source_state,
  input  wire logic [scc_pkg::SW-1:0]      target_state,
  output logic                             done,
  output logic      [scc_pkg::NW-1:0]      component_total,
  output logic      [scc_pkg::SW-1:0]      component_index,
  output logic                             in_kept_component,
  output logic                             error_flag,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [scc_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [scc_pkg::CFG_DW-1:0]  cfg_data
);

  import scc_pkg::*;

  state_t         state, state_next;
  logic [SW-1:0]  idx;
  logic [NW-1:0]  state_count, n_r, n_eff, v, cnt, next_pre, k, kept_total;
  logic [NW-1:0]  otop, rtop, wtop, otop_m1, rtop_m1, wtop_m1;
  logic           drop_trivial, only_bottom;
  logic [EFW-1:0] fill, cur_lo, cursor, end_e, lo_new;
  logic [SW-1:0]  last_src, cur, t_r, pre_t, c_r;
  logic [1:0]     size_r;
  logic           self_r, accept, edge_err;

  logic           subset_we, subset_wd, subset_rd;
  logic [SW-1:0]  subset_wa, subset_ra;
  logic           row_we;
  logic [SW-1:0]  row_wa, row_ra;
  row_t           row_wd, row_rd;
  logic           edge_we;
  logic [EW-1:0]  edge_wa, edge_ra;
  logic [SW-1:0]  edge_wd, edge_rd;
  logic           node_we;
  logic [SW-1:0]  node_wa, node_ra;
  node_t          node_wd, node_rd;
  logic           open_we;
  logic [SW-1:0]  open_wa, open_ra, open_wd, open_rd;
  logic           root_we;
  logic [SW-1:0]  root_wa, root_ra;
  root_t          root_wd, root_rd;
  logic           walk_we;
  logic [SW-1:0]  walk_wa, walk_ra;
  frame_t         walk_wd, walk_rd;
  logic           comp_we;
  logic [SW-1:0]  comp_wa, comp_ra;
  comp_t          comp_wd, comp_rd;

  scc_ram #(.W(1), .D(MAX_STATES)) u_subset (
    .clk, .we(subset_we), .waddr(subset_wa), .wdata(subset_wd),
    .raddr(subset_ra), .rdata(subset_rd));
  scc_ram #(.W($bits(row_t)), .D(MAX_STATES)) u_row (
    .clk, .we(row_we), .waddr(row_wa), .wdata(row_wd), .raddr(row_ra), .rdata(row_rd));
  scc_ram #(.W(SW), .D(MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));
  scc_ram #(.W($bits(node_t)), .D(MAX_STATES)) u_node (
    .clk, .we(node_we), .waddr(node_wa), .wdata(node_wd), .raddr(node_ra),
    .rdata(node_rd));
  scc_ram #(.W(SW), .D(MAX_STATES)) u_open (
    .clk, .we(open_we), .waddr(open_wa), .wdata(open_wd), .raddr(open_ra),
    .rdata(open_rd));
  scc_ram #(.W($bits(root_t)), .D(MAX_STATES)) u_root (
    .clk, .we(root_we), .waddr(root_wa), .wdata(root_wd), .raddr(root_ra),
    .rdata(root_rd));
  scc_ram #(.W($bits(frame_t)), .D(MAX_STATES)) u_walk (
    .clk, .we(walk_we), .waddr(walk_wa), .wdata(walk_wd), .raddr(walk_ra),
    .rdata(walk_rd));
  scc_ram #(.W($bits(comp_t)), .D(MAX_STATES)) u_comp (
    .clk, .we(comp_we), .waddr(comp_wa), .wdata(comp_wd), .raddr(comp_ra),
    .rdata(comp_rd));

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign otop_m1   = otop - 1'b1;
  assign rtop_m1   = rtop - 1'b1;
  assign wtop_m1   = wtop - 1'b1;
  assign n_eff     = (state_count > NW'(MAX_STATES)) ? NW'(MAX_STATES) : state_count;
  assign edge_err  = (fill >= EFW'(MAX_EDGES)) || (fill != '0 && source_state < last_src);
  assign lo_new    = (fill != '0 && source_state == last_src) ? cur_lo : fill;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (idx == SW'(MAX_STATES - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_RUN:   state_next = ST_RINIT;
            ACT_QUERY: state_next = ST_Q1;
            ACT_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_Q1:     state_next = node_rd.assigned ? ST_Q2 : ST_IDLE;
      ST_Q2:     state_next = ST_IDLE;
      ST_RINIT:  if (idx == SW'(MAX_STATES - 1)) state_next = ST_SCAN;
      ST_SCAN: begin
        if (v >= n_r) state_next = only_bottom ? ST_B_RD : ST_RN_RD;
        else          state_next = ST_SCAN_W;
      end
      ST_SCAN_W: state_next = (subset_rd && !node_rd.visited) ? ST_ENTER : ST_SCAN;
      ST_ENTER:  state_next = ST_EDGE;
      ST_EDGE:   state_next = (cursor < end_e) ? ST_EDGE_T : ST_DONE1;
      ST_EDGE_T: state_next = ({1'b0, edge_rd} < n_r) ? ST_EDGE_N : ST_EDGE;
      ST_EDGE_N: begin
        priority if (!subset_rd)        state_next = ST_EDGE;
        else if (!node_rd.visited)      state_next = ST_DESC;
        else if (!node_rd.assigned)     state_next = ST_ROOT;
        else                            state_next = ST_EDGE;
      end
      ST_DESC:   state_next = ST_ENTER;
      ST_ROOT:   state_next = (rtop == '0) ? ST_EDGE : ST_ROOT_W;
      ST_ROOT_W: state_next = (root_rd.pre > pre_t) ? ST_ROOT : ST_EDGE;
      ST_DONE1:  state_next = (rtop == '0) ? ST_POPW : ST_DONE2;
      ST_DONE2:  state_next = (root_rd.node == cur) ? ST_POPO : ST_POPW;
      ST_POPO:   state_next = (otop == '0) ? ST_COMP : ST_POPO_W;
      ST_POPO_W: state_next = (open_rd == cur) ? ST_COMP : ST_POPO;
      ST_COMP:   state_next = ST_POPW;
      ST_POPW:   state_next = (wtop == '0) ? ST_SCAN : ST_POPW_W;
      ST_POPW_W: state_next = ST_POPW_R;
      ST_POPW_R: state_next = ST_EDGE;
      ST_B_RD:   state_next = (v >= n_r) ? ST_RN_RD : ST_B_N;
      ST_B_N:    state_next = node_rd.assigned ? ST_B_C : ST_B_RD;
      ST_B_C:    state_next = comp_rd.drop ? ST_B_RD : ST_B_E;
      ST_B_E:    state_next = (cursor < end_e) ? ST_B_ET : ST_B_RD;
      ST_B_ET:   state_next = ST_B_EN;
      ST_B_EN: begin
        if (node_rd.assigned && node_rd.comp != c_r) state_next = ST_B_RD;
        else                                         state_next = ST_B_E;
      end
      ST_RN_RD:  state_next = (v >= cnt) ? ST_IDLE : ST_RN_W;
      ST_RN_W:   state_next = ST_RN_RD;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    subset_we = 1'b0; subset_wa = '0; subset_wd = 1'b0; subset_ra = '0;
    row_we = 1'b0; row_wa = '0; row_wd = '0; row_ra = '0;
    edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
    node_we = 1'b0; node_wa = '0; node_wd = '0; node_ra = '0;
    open_we = 1'b0; open_wa = '0; open_wd = '0; open_ra = '0;
    root_we = 1'b0; root_wa = '0; root_wd = '0; root_ra = '0;
    walk_we = 1'b0; walk_wa = '0; walk_wd = '0; walk_ra = '0;
    comp_we = 1'b0; comp_wa = '0; comp_wd = '0; comp_ra = '0;
    unique case (state)
      ST_CLEAR: begin
        subset_we = 1'b1; subset_wa = idx;
        row_we = 1'b1; row_wa = idx;
        node_we = 1'b1; node_wa = idx;
      end
      ST_IDLE: begin
        node_ra = source_state;
        if (accept && action == ACT_MARK) begin
          subset_we = 1'b1; subset_wa = source_state; subset_wd = 1'b1;
        end
        if (accept && action == ACT_EDGE && !edge_err) begin
          edge_we = 1'b1; edge_wa = fill[EW-1:0]; edge_wd = target_state;
          row_we = 1'b1; row_wa = source_state;
          row_wd.lo = lo_new; row_wd.hi = fill + 1'b1;
        end
      end
      ST_Q1:     comp_ra = node_rd.comp;
      ST_RINIT: begin
        node_we = 1'b1; node_wa = idx;
      end
      ST_SCAN: begin
        subset_ra = v[SW-1:0]; node_ra = v[SW-1:0]; row_ra = v[SW-1:0];
      end
      ST_ENTER: begin
        node_we = 1'b1; node_wa = cur;
        node_wd.visited = 1'b1; node_wd.pre = next_pre[SW-1:0];
        open_we = 1'b1; open_wa = otop[SW-1:0]; open_wd = cur;
        root_we = 1'b1; root_wa = rtop[SW-1:0];
        root_wd.node = cur; root_wd.pre = next_pre[SW-1:0];
      end
      ST_EDGE:   edge_ra = cursor[EW-1:0];
      ST_EDGE_T: begin
        subset_ra = edge_rd; node_ra = edge_rd;
      end
      ST_EDGE_N: begin
        row_ra = t_r;
        if (subset_rd && t_r == cur) begin
          node_we = 1'b1; node_wa = cur; node_wd = node_rd; node_wd.self_loop = 1'b1;
        end
        if (subset_rd && !node_rd.visited) begin
          walk_we = 1'b1; walk_wa = wtop[SW-1:0];
          walk_wd.node = cur; walk_wd.cursor = cursor;
        end
      end
      ST_ROOT:   root_ra = rtop_m1[SW-1:0];
      ST_DONE1: begin
        root_ra = rtop_m1[SW-1:0]; node_ra = cur;
      end
      ST_POPO:   open_ra = otop_m1[SW-1:0];
      ST_POPO_W: begin
        node_we = 1'b1; node_wa = open_rd;
        node_wd.visited = 1'b1; node_wd.assigned = 1'b1; node_wd.comp = cnt[SW-1:0];
      end
      ST_COMP: begin
        comp_we = 1'b1; comp_wa = cnt[SW-1:0];
        comp_wd.drop = drop_trivial && size_r == 2'd1 && !self_r;
      end
      ST_POPW:   walk_ra = wtop_m1[SW-1:0];
      ST_POPW_W: row_ra = walk_rd.node;
      ST_B_RD:   node_ra = v[SW-1:0];
      ST_B_N: begin
        comp_ra = node_rd.comp; row_ra = v[SW-1:0];
      end
      ST_B_E:    edge_ra = cursor[EW-1:0];
      ST_B_ET:   node_ra = edge_rd;
      ST_B_EN: begin
        if (node_rd.assigned && node_rd.comp != c_r) begin
          comp_we = 1'b1; comp_wa = c_r; comp_wd.drop = 1'b1;
        end
      end
      ST_RN_RD:  comp_ra = v[SW-1:0];
      ST_RN_W: begin
        if (!comp_rd.drop) begin
          comp_we = 1'b1; comp_wa = v[SW-1:0]; comp_wd.renum = k[SW-1:0];
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      idx          <= '0;
      fill         <= '0;
      kept_total   <= '0;
      done         <= 1'b0;
      otop         <= '0;
      rtop         <= '0;
      state_count  <= NW'(MAX_STATES);
      drop_trivial <= 1'b0;
      only_bottom  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_STATE_COUNT:  state_count  <= cfg_data;
          CFG_DROP_TRIVIAL: drop_trivial <= cfg_data[0];
          CFG_ONLY_BOTTOM:  only_bottom  <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state)
        ST_CLEAR: begin
          idx        <= idx + 1'b1;
          fill       <= '0;
          kept_total <= '0;
        end
        ST_IDLE: begin
          if (accept) begin
            case (action)
              ACT_EDGE: begin
                done              <= 1'b1;
                component_total   <= '0;
                component_index   <= '0;
                in_kept_component <= 1'b0;
                error_flag        <= edge_err;
                if (!edge_err) begin
                  fill     <= fill + 1'b1;
                  last_src <= source_state;
                  cur_lo   <= lo_new;
                end
              end
              ACT_RUN: begin
                idx      <= '0;
                n_r      <= n_eff;
                v        <= '0;
                otop     <= '0;
                rtop     <= '0;
                wtop     <= '0;
                next_pre <= '0;
                cnt      <= '0;
              end
              ACT_CLEAR: idx <= '0;
              default: ;
            endcase
          end
        end
        ST_Q1: begin
          if (!node_rd.assigned) begin
            done              <= 1'b1;
            component_total   <= kept_total;
            component_index   <= '0;
            in_kept_component <= 1'b0;
            error_flag        <= 1'b0;
          end
        end
        ST_Q2: begin
          done              <= 1'b1;
          component_total   <= kept_total;
          component_index   <= comp_rd.drop ? '0 : comp_rd.renum;
          in_kept_component <= !comp_rd.drop;
          error_flag        <= 1'b0;
        end
        ST_RINIT: idx <= idx + 1'b1;
        ST_SCAN: begin
          if (v >= n_r) begin
            v <= '0;
            k <= '0;
          end
        end
        ST_SCAN_W: begin
          if (subset_rd && !node_rd.visited) begin
            cur    <= v[SW-1:0];
            cursor <= row_rd.lo;
            end_e  <= row_rd.hi;
            wtop   <= '0;
          end else begin
            v <= v + 1'b1;
          end
        end
        ST_ENTER: begin
          otop     <= otop + 1'b1;
          rtop     <= rtop + 1'b1;
          next_pre <= next_pre + 1'b1;
        end
        ST_EDGE: ;
        ST_EDGE_T: begin
          t_r <= edge_rd;
          if (!({1'b0, edge_rd} < n_r)) cursor <= cursor + 1'b1;
        end
        ST_EDGE_N: begin
          priority if (!subset_rd) begin
            cursor <= cursor + 1'b1;
          end else if (!node_rd.visited) begin
            wtop <= wtop + 1'b1;
            cur  <= t_r;
          end else if (!node_rd.assigned) begin
            pre_t <= node_rd.pre;
          end else begin
            cursor <= cursor + 1'b1;
          end
        end
        ST_DESC: begin
          cursor <= row_rd.lo;
          end_e  <= row_rd.hi;
        end
        ST_ROOT: if (rtop == '0) cursor <= cursor + 1'b1;
        ST_ROOT_W: begin
          if (root_rd.pre > pre_t) rtop <= rtop - 1'b1;
          else                     cursor <= cursor + 1'b1;
        end
        ST_DONE1: ;
        ST_DONE2: begin
          if (root_rd.node == cur) begin
            rtop   <= rtop - 1'b1;
            size_r <= '0;
            self_r <= node_rd.self_loop;
          end
        end
        ST_POPO:   if (otop != '0) otop <= otop - 1'b1;
        ST_POPO_W: if (size_r != 2'd2) size_r <= size_r + 1'b1;
        ST_COMP:   cnt <= cnt + 1'b1;
        ST_POPW: begin
          if (wtop == '0) v <= v + 1'b1;
          else            wtop <= wtop - 1'b1;
        end
        ST_POPW_W: begin
          cur    <= walk_rd.node;
          cursor <= walk_rd.cursor;
        end
        ST_POPW_R: end_e <= row_rd.hi;
        ST_B_RD: begin
          if (v >= n_r) begin
            v <= '0;
            k <= '0;
          end
        end
        ST_B_N: begin
          if (!node_rd.assigned) v <= v + 1'b1;
          else                   c_r <= node_rd.comp;
        end
        ST_B_C: begin
          if (comp_rd.drop) begin
            v <= v + 1'b1;
          end else begin
            cursor <= row_rd.lo;
            end_e  <= row_rd.hi;
          end
        end
        ST_B_E:  if (!(cursor < end_e)) v <= v + 1'b1;
        ST_B_ET: ;
        ST_B_EN: begin
          if (node_rd.assigned && node_rd.comp != c_r) v <= v + 1'b1;
          else                                         cursor <= cursor + 1'b1;
        end
        ST_RN_RD: begin
          if (v >= cnt) begin
            done              <= 1'b1;
            component_total   <= k;
            component_index   <= '0;
            in_kept_component <= 1'b0;
            error_flag        <= 1'b0;
            kept_total        <= k;
          end
        end
        ST_RN_W: begin
          if (!comp_rd.drop) k <= k + 1'b1;
          v <= v + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_IDLE)
    else $error("result strobe outside idle");

  a_err_from_edge: assert property (@(posedge clk) disable iff (rst)
    done && error_flag |-> $past(accept && action == ACT_EDGE))
    else $error("error flag without an edge transfer");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    done && in_kept_component |-> {1'b0, component_index} < component_total)
    else $error("component index beyond total");

  a_root_le_open: assert property (@(posedge clk) disable iff (rst)
    rtop <= otop)
    else $error("root stack deeper than open stack");

endmodule

`default_nettype wire
